FILE: rtl/hplq_pkg.sv
package hplq_pkg;

   localparam int TableEntries = 257;
   localparam int IndexWidth = 9;
   localparam int SearchSteps = 9;

   localparam logic [1:0] ClassNormal = 2'd0;
   localparam logic [1:0] ClassNanInf = 2'd1;
   localparam logic [1:0] ClassNegative = 2'd2;

   localparam logic OpMap = 1'b0;
   localparam logic OpLoad = 1'b1;

   localparam logic [0:0] RegNegativeColor = 1'b0;
   localparam logic [0:0] RegNanInfColor = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [8:0]  entry_index;
      logic [31:0] entry_value;
      logic [31:0] red_bits;
      logic [31:0] green_bits;
      logic [31:0] blue_bits;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_word;
      logic [1:0]  pixel_class;
   } rsp_type;

   function automatic logic is_nan(input logic [31:0] u);
      return u[30:0] > 31'h7F800000;
   endfunction

   function automatic logic is_nan_inf(input logic [31:0] u);
      return u[30:23] == 8'hFF;
   endfunction

   function automatic logic is_negative(input logic [31:0] u);
      return u[31] && (u[30:0] != 31'd0) && !is_nan(u);
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] u);
      return u[31] ? ~u : (u | 32'h80000000);
   endfunction

   // IEEE a < b
   function automatic logic float_less(input logic [31:0] a, input logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
      return order_key(a) < order_key(b);
   endfunction

endpackage

FILE: rtl/hplq_ram.sv
module hplq_ram #(
   parameter int Width = 32,
   parameter int Depth = 257
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: rtl/hplq_search_lane.sv
module hplq_search_lane #(
   parameter int TABLE_ENTRIES = hplq_pkg::TableEntries
) (
   input  logic                       clock,
   input  logic                       start,
   input  logic                       step,
   input  logic [31:0]                channel,
   input  logic [31:0]                threshold,
   output logic [hplq_pkg::IndexWidth-1:0] probe_addr,
   output logic [7:0]                 channel_byte
);
   import hplq_pkg::*;

   logic [9:0] lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [9:0] sum;

   assign sum = lo_ff + hi_ff;
   assign mid = {1'b0, sum[9:1]};
   assign probe_addr = IndexWidth'(mid - 10'd1);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (start) begin
         lo_in = 10'd0;
         hi_in = 10'(TABLE_ENTRIES + 1);
      end else if (step && mid != lo_ff) begin
         if (float_less(channel, threshold)) hi_in = mid;
         else lo_in = mid;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   always_comb begin
      if (lo_ff == 10'd0) channel_byte = 8'd0;
      else if (lo_ff - 10'd1 > 10'd255) channel_byte = 8'd255;
      else channel_byte = 8'(lo_ff - 10'd1);
   end
endmodule

FILE: rtl/hdr_pixel_lut_quantizer_unit.sv
// Tone mapper: a load word (opcode 1) writes one of 257 float32 thresholds. A
// map word (opcode 0) binary-searches the table for its three channels side by
// side, nine probes per channel, each a registered table read (READ state),
// then a compare (PROBE state); no new word is taken before its result is written.
// Three table RAMs hold identical copies so each channel has its own read port.
// The result waits in an output register; no word is taken while it waits,
// except in the cycle in which the result itself is taken.
module hdr_pixel_lut_quantizer_unit #(
   parameter int TABLE_ENTRIES = hplq_pkg::TableEntries
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hplq_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hplq_pkg::rsp_type     rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import hplq_pkg::*;

   typedef enum logic [1:0] {IDLE, READ, PROBE, DONE} state_type;

   state_type state_ff;
   logic [3:0] count_ff;
   req_type item_ff;
   logic [31:0] neg_ff, naninf_ff;
   logic [8:0] addr [3];
   logic [31:0] thr [3];
   logic [7:0] bytes [3];
   logic [31:0] chans [3];
   logic accept, wr_en, csr_wr;
   logic any_neg, any_ni;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? naninf_ff : neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff <= '0;
         naninf_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr == {RegNegativeColor, 2'b00}) neg_ff <= csr_pwdata;
         else if (csr_paddr == {RegNanInfColor, 2'b00}) naninf_ff <= csr_pwdata;
      end
   end

   assign req_ready = (state_ff == IDLE) && (!rsp_valid || rsp_ready);
   assign accept = req_valid && req_ready;
   assign wr_en = accept && req_data.opcode == OpLoad
                  && req_data.entry_index < 9'(TABLE_ENTRIES);

   assign chans[0] = item_ff.red_bits;
   assign chans[1] = item_ff.green_bits;
   assign chans[2] = item_ff.blue_bits;

   for (genvar g = 0; g < 3; g++) begin : g_lane
      hplq_ram #(.Width(32), .Depth(TABLE_ENTRIES)) u_ram (
         .clock(clock), .wr_en(wr_en), .wr_addr(req_data.entry_index),
         .wr_data(req_data.entry_value), .rd_addr(addr[g]), .rd_data(thr[g]));
      hplq_search_lane #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_lane (
         .clock(clock), .start(accept), .step(state_ff == PROBE),
         .channel(chans[g]), .threshold(thr[g]),
         .probe_addr(addr[g]), .channel_byte(bytes[g]));
   end

   assign any_neg = is_negative(chans[0]) || is_negative(chans[1]) || is_negative(chans[2]);
   assign any_ni = is_nan_inf(chans[0]) || is_nan_inf(chans[1]) || is_nan_inf(chans[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid <= 1'b0;
         count_ff <= '0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (accept && req_data.opcode == OpMap) begin
                  item_ff <= req_data;
                  count_ff <= '0;
                  state_ff <= READ;
               end
            end
            READ: state_ff <= PROBE;
            PROBE: begin
               count_ff <= count_ff + 4'd1;
               state_ff <= (count_ff == 4'(SearchSteps - 1)) ? DONE : READ;
            end
            DONE: begin
               rsp_valid <= 1'b1;
               if (any_neg) begin
                  rsp_data.pixel_word <= neg_ff;
                  rsp_data.pixel_class <= ClassNegative;
               end else if (any_ni) begin
                  rsp_data.pixel_word <= naninf_ff;
                  rsp_data.pixel_class <= ClassNanInf;
               end else begin
                  rsp_data.pixel_word <= {8'hFF, bytes[0], bytes[1], bytes[2]};
                  rsp_data.pixel_class <= ClassNormal;
               end
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff != IDLE |-> !req_ready) else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == DONE |=> rsp_valid) else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pixel_class == ClassNormal |-> rsp_data.pixel_word[31:24] == 8'hFF)
      else $error("bad alpha");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 4'(SearchSteps)) else $error("probe count overrun");
endmodule
